FILE: sv/column_melt_wipe_addresser_assert.svh
// Assertion macros for the column melt wipe addresser.
// Depends on nothing; included by the modules that carry assertions.
`ifndef COLUMN_MELT_WIPE_ADDRESSER_ASSERT_SVH
`define COLUMN_MELT_WIPE_ADDRESSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CMWA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CMWA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/cmwa_pkg.sv
// Shared constants, payload types and arithmetic helpers of the column melt wipe addresser.
// Depends on nothing; the cell, seeder, top level and testbench use it by scoped names.
package cmwa_pkg;

   // Screen geometry.
   localparam int NUM_COLUMNS = 160;
   localparam int SCREEN_ROWS = 200;
   localparam int COL_AW      = $clog2(NUM_COLUMNS);
   localparam int OFFSET_W    = 10;
   localparam int DROP_STEP   = SCREEN_ROWS / 16;

   // Generator constants.
   localparam logic [31:0] LCG_MUL    = 32'd214013;
   localparam logic [31:0] LCG_ADD    = 32'd2531011;
   localparam logic [31:0] SEED_RESET = 32'd12345;
   // Reciprocal of three scaled by 2^16, exact for 15-bit operands.
   localparam logic [14:0] RECIP_3    = 15'd21846;

   // Opcodes.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic signed [OFFSET_W-1:0] offset_type;
   typedef logic signed [4:0]          start_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] column;
      logic [7:0] row;
   } req_type;

   typedef struct packed {
      logic       done_res;
      logic       from_end;
      logic [7:0] source_row;
   } rsp_type;

   // Sequencer controls for the start value generator.
   typedef struct packed {
      logic load;
      logic fresh;
      logic first;
   } seed_ctl_type;

   // One step of the linear congruential generator.
   function automatic logic [31:0] lcg_step(logic [31:0] s);
      logic [31:0] prod;
      prod = s * LCG_MUL;
      return prod + LCG_ADD;
   endfunction

   // Remainder by three through a reciprocal multiply.
   function automatic logic [1:0] mod3(logic [14:0] x);
      logic [29:0] prod;
      logic [13:0] q;
      logic [16:0] r;
      prod = x * RECIP_3;
      q    = prod[29:16];
      r    = 17'(x) - (17'(q) + 17'({q, 1'b0}));
      return r[1:0];
   endfunction

   // One frame of motion for a single column offset.
   function automatic offset_type advance_offset(offset_type v);
      offset_type r;
      if (v < 0) begin
         r = v + offset_type'(1);
      end else if (v < offset_type'(16)) begin
         r = v + v + offset_type'(1);
      end else if (v < offset_type'(SCREEN_ROWS)) begin
         if ((offset_type'(SCREEN_ROWS) - v) < offset_type'(DROP_STEP)) begin
            r = offset_type'(SCREEN_ROWS);
         end else begin
            r = v + offset_type'(DROP_STEP);
         end
      end else begin
         r = v;
      end
      return r;
   endfunction

   // True once a column has fallen the whole screen.
   function automatic logic reached(offset_type v);
      return v >= offset_type'(SCREEN_ROWS);
   endfunction

endpackage

FILE: sv/cmwa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module cmwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cmwa_cell.sv
// One cell of the column chain: holds one drop offset and takes its neighbor's on a shift.
// Depends on cmwa_pkg.
module cmwa_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  cmwa_pkg::offset_type neighbor_offset,
   output cmwa_pkg::offset_type drop_offset
);

   cmwa_pkg::offset_type drop_offset_ff;

   // Offsets start at zero and move one cell per shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_offset_ff <= '0;
      end else if (shift_en) begin
         drop_offset_ff <= neighbor_offset;
      end
   end

   assign drop_offset = drop_offset_ff;

endmodule

FILE: sv/cmwa_seeder.sv
// Start value generator: the generator state and the random walk of column pair offsets.
// Depends on cmwa_pkg.
module cmwa_seeder (
   input  logic                   clock,
   input  logic                   reset,
   input  cmwa_pkg::seed_ctl_type ctl,
   input  logic [31:0]            seed,
   output cmwa_pkg::start_type    start_value
);

   logic [31:0]         lcg_ff;
   cmwa_pkg::start_type prev_ff;
   logic [14:0]         rand_w;
   logic [1:0]          rem_w;
   logic signed [5:0]   sum_w;
   cmwa_pkg::start_type first_w;
   cmwa_pkg::start_type walk_w;

   // Random value drawn from the current generator state.
   assign rand_w  = lcg_ff[30:16];
   assign rem_w   = cmwa_pkg::mod3(rand_w);
   assign first_w = cmwa_pkg::start_type'(0) - cmwa_pkg::start_type'({1'b0, lcg_ff[19:16]});

   // Walk from the previous pair by minus one, zero or plus one, kept within -15..0.
   assign sum_w = $signed({prev_ff[4], prev_ff}) + $signed({4'b0, rem_w}) - 6'sd1;

   always_comb begin
      if (sum_w < -6'sd15) begin
         walk_w = -5'sd15;
      end else if (sum_w > 6'sd0) begin
         walk_w = 5'sd0;
      end else begin
         walk_w = cmwa_pkg::start_type'(sum_w);
      end
   end

   // A new value opens each pair; the second column of a pair repeats it.
   assign start_value = ctl.fresh ? (ctl.first ? first_w : walk_w) : prev_ff;

   // Generator steps once per pair, reloaded from the seed at each wipe start.
   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff <= cmwa_pkg::SEED_RESET;
      end else if (ctl.load) begin
         lcg_ff <= cmwa_pkg::lcg_step(seed);
      end else if (ctl.fresh) begin
         lcg_ff  <= cmwa_pkg::lcg_step(lcg_ff);
         prev_ff <= start_value;
      end
   end

endmodule

FILE: sv/column_melt_wipe_addresser.sv
// Top level of the column melt wipe addresser: sequencer, column chain and query mirror.
// Depends on cmwa_pkg, cmwa_cell, cmwa_seeder, cmwa_ram and the assertion header.
//
//   Channel  Ports                       Direction  Carries
//   req      req_valid/req_stall/req_data  in       opcode, column, row
//   rsp      rsp_valid/rsp_stall/rsp_data  out      done_res, from_end, source_row
//   csr      csr_wr_en/csr_wr_data         in       rng_seed
//
// A query is accepted with a registered mirror read, then the result is loaded.
// A tick rotates the chain once through the advance logic, then loads the result; a tick that
// starts a wipe first passes through a start state to seed the generator and a fill pass of the chain.
// Reset is synchronous; it zeroes the chain and marks the mirror empty, with no clearing pass.
// req_stall is high whenever an item is in progress; a result waits in the output register
// while rsp_stall is high, and the next item is accepted meanwhile.
`include "column_melt_wipe_addresser_assert.svh"

module column_melt_wipe_addresser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cmwa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cmwa_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_INIT,
      ST_ADVANCE,
      ST_FINISH,
      ST_QUERY
   } state_type;

   state_type                     state_ff;
   logic [cmwa_pkg::COL_AW-1:0]   idx_ff;
   logic [cmwa_pkg::COL_AW-1:0]   col_ff;
   logic [7:0]                    row_ff;
   logic                          in_range_ff;
   logic                          done_ff;
   logic                          wipe_active_ff;
   logic                          mirror_ff;
   logic [31:0]                   seed_ff;
   logic                          rsp_valid_ff;
   cmwa_pkg::rsp_type             rsp_data_ff;

   cmwa_pkg::offset_type          chain_w [cmwa_pkg::NUM_COLUMNS];
   cmwa_pkg::offset_type          feed_in;
   cmwa_pkg::start_type           start_value;
   cmwa_pkg::seed_ctl_type        seed_ctl;
   logic                          shift_en;
   logic                          last_w;
   logic                          done_in;
   logic                          out_free;
   logic [cmwa_pkg::COL_AW-1:0]   rd_addr;
   logic [cmwa_pkg::OFFSET_W-1:0] rd_data;
   cmwa_pkg::offset_type          q_off;
   logic [8:0]                    clip_w;
   cmwa_pkg::rsp_type             query_rsp;

   // Handshake and shared control.
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign shift_en  = (state_ff == ST_INIT) || (state_ff == ST_ADVANCE);
   assign last_w    = (idx_ff == cmwa_pkg::COL_AW'(cmwa_pkg::NUM_COLUMNS - 1));
   assign done_in   = done_ff && cmwa_pkg::reached(chain_w[0]);

   // Start value generator draws a new value on each even fill step, one per column pair.
   assign seed_ctl.load  = (state_ff == ST_START);
   assign seed_ctl.fresh = (state_ff == ST_INIT) && !idx_ff[0];
   assign seed_ctl.first = (idx_ff == '0);

   cmwa_seeder u_seeder (
      .clock       (clock),
      .reset       (reset),
      .ctl         (seed_ctl),
      .seed        (seed_ff),
      .start_value (start_value)
   );

   // Value entering the far end of the chain: a start value or the advanced head column.
   assign feed_in = (state_ff == ST_INIT) ? cmwa_pkg::offset_type'(start_value)
                                          : cmwa_pkg::advance_offset(chain_w[0]);

   // Chain of column cells; the head leaves and re-enters at the tail, so order is kept.
   for (genvar j = 0; j < cmwa_pkg::NUM_COLUMNS; j++) begin : g_cell
      if (j < cmwa_pkg::NUM_COLUMNS - 1) begin : g_mid
         cmwa_cell u_cell (
            .clock           (clock),
            .reset           (reset),
            .shift_en        (shift_en),
            .neighbor_offset (chain_w[j+1]),
            .drop_offset     (chain_w[j])
         );
      end else begin : g_tail
         cmwa_cell u_cell (
            .clock           (clock),
            .reset           (reset),
            .shift_en        (shift_en),
            .neighbor_offset (feed_in),
            .drop_offset     (chain_w[j])
         );
      end
   end

   // Mirror of the offsets for queries, written as each column passes the tail.
   assign rd_addr = (state_ff == ST_IDLE) ? cmwa_pkg::COL_AW'(req_data.column) : col_ff;

   cmwa_ram #(
      .WIDTH (cmwa_pkg::OFFSET_W),
      .DEPTH (cmwa_pkg::NUM_COLUMNS)
   ) u_mirror (
      .clock   (clock),
      .wr_en   (shift_en),
      .wr_addr (idx_ff),
      .wr_data (feed_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Query rule: rows above the clipped offset come from the end frame.
   assign q_off = rd_data;

   always_comb begin
      if (!in_range_ff || !mirror_ff || (q_off < 0)) begin
         clip_w = '0;
      end else begin
         clip_w = q_off[8:0];
      end
      query_rsp.done_res = 1'b0;
      query_rsp.from_end = ({1'b0, row_ff} < clip_w);
      if (query_rsp.from_end) begin
         query_rsp.source_row = row_ff;
      end else begin
         query_rsp.source_row = 8'({1'b0, row_ff} - clip_w);
      end
   end

   // Sequencer, configuration register and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         done_ff        <= 1'b1;
         wipe_active_ff <= 1'b0;
         mirror_ff      <= 1'b0;
         seed_ff        <= cmwa_pkg::SEED_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         // The output register empties when taken and loads when a result is ready.
         if (out_free) begin
            rsp_valid_ff <= (state_ff == ST_FINISH) || (state_ff == ST_QUERY);
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  col_ff      <= cmwa_pkg::COL_AW'(req_data.column);
                  row_ff      <= req_data.row;
                  in_range_ff <= (32'(req_data.column) < 32'(cmwa_pkg::NUM_COLUMNS));
                  idx_ff      <= '0;
                  done_ff     <= 1'b1;
                  if (req_data.opcode == cmwa_pkg::OP_QUERY) begin
                     state_ff <= ST_QUERY;
                  end else if (!wipe_active_ff) begin
                     state_ff <= ST_START;
                  end else begin
                     state_ff <= ST_ADVANCE;
                  end
               end
            end
            ST_START: begin
               wipe_active_ff <= 1'b1;
               idx_ff         <= '0;
               state_ff       <= ST_INIT;
            end
            ST_INIT: begin
               if (last_w) begin
                  idx_ff    <= '0;
                  mirror_ff <= 1'b1;
                  done_ff   <= 1'b1;
                  state_ff  <= ST_ADVANCE;
               end else begin
                  idx_ff <= idx_ff + cmwa_pkg::COL_AW'(1);
               end
            end
            ST_ADVANCE: begin
               done_ff <= done_in;
               if (last_w) begin
                  idx_ff         <= '0;
                  wipe_active_ff <= !done_in;
                  state_ff       <= ST_FINISH;
               end else begin
                  idx_ff <= idx_ff + cmwa_pkg::COL_AW'(1);
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_data_ff.done_res   <= done_ff;
                  rsp_data_ff.from_end   <= 1'b0;
                  rsp_data_ff.source_row <= 8'd0;
                  state_ff               <= ST_IDLE;
               end
            end
            ST_QUERY: begin
               if (out_free) begin
                  rsp_data_ff <= query_rsp;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The pass counter never runs past the last column.
   `CMWA_ASSERT_NOW(a_idx_bound, clock, reset,
      (state_ff == ST_INIT) || (state_ff == ST_ADVANCE),
      idx_ff <= cmwa_pkg::COL_AW'(cmwa_pkg::NUM_COLUMNS - 1),
      "pass counter ran past the last column")

   // After a full advance pass the wipe stays active exactly when it is not done.
   `CMWA_ASSERT_NOW(a_active_vs_done, clock, reset,
      state_ff == ST_FINISH,
      wipe_active_ff == !done_ff,
      "wipe active flag disagrees with the done result")

   // An accepted tick always starts a pass.
   `CMWA_ASSERT_NEXT(a_tick_busy, clock, reset,
      req_valid && !req_stall && (req_data.opcode == cmwa_pkg::OP_TICK),
      (state_ff == ST_START) || (state_ff == ST_ADVANCE),
      "accepted tick did not start a pass")

   // A result is either a tick result or a query result, never both.
   `CMWA_ASSERT_NOW(a_rsp_kind, clock, reset,
      rsp_valid_ff && rsp_data_ff.done_res,
      !rsp_data_ff.from_end && (rsp_data_ff.source_row == 8'd0),
      "done result carries query fields")

endmodule

FILE: test/column_melt_wipe_addresser_test.sv
// Self-checking testbench of the column melt wipe addresser: directed items, then random phases.
// Depends on cmwa_pkg and the column_melt_wipe_addresser RTL; it reads no files.
// A scoreboard class predicts every result and checks the block's results in order.
module column_melt_wipe_addresser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int TICK_CYCLES  = 2 * cmwa_pkg::NUM_COLUMNS + 2;
   localparam int MAX_PRINTED  = 40;
   localparam int PHASE_ITEMS  = 200;
   localparam logic [31:0] GEN_MUL = 32'd214013;
   localparam logic [31:0] GEN_ADD = 32'd2531011;
   localparam logic [31:0] GEN_INIT = 32'd12345;

   typedef enum int {STALL_NONE, STALL_SCATTER, STALL_BURSTY} stall_style_type;

   // Tracks the column offsets and generator, predicts each result and checks it.
   class wipe_scoreboard;
      cmwa_pkg::offset_type drop[cmwa_pkg::NUM_COLUMNS];
      logic [31:0]          lcg;
      logic [31:0]          seed;
      bit                   active;
      cmwa_pkg::rsp_type    pending_rsp[$];
      int                   errors;
      int                   ticks;
      int                   queries;
      int                   wipes_done;
      int                   end_reads;

      function new();
         foreach (drop[i]) drop[i] = '0;
         lcg        = GEN_INIT;
         seed       = GEN_INIT;
         active     = 1'b0;
         errors     = 0;
         ticks      = 0;
         queries    = 0;
         wipes_done = 0;
         end_reads  = 0;
      endfunction

      // One step of the generator, giving bits 30 down to 16 of the new state.
      function int draw_random();
         lcg = lcg * GEN_MUL + GEN_ADD;
         return int'((lcg >> 16) & 32'h7FFF);
      endfunction

      // Loads the seed and sets the starting offsets, two columns at a time.
      function void seed_columns();
         int level;
         lcg   = seed;
         level = -(draw_random() & 15);
         drop[0] = cmwa_pkg::offset_type'(level);
         drop[1] = cmwa_pkg::offset_type'(level);
         for (int i = 2; i < cmwa_pkg::NUM_COLUMNS; i += 2) begin
            level = level + (draw_random() % 3) - 1;
            if (level < -15) level = -15;
            if (level > 0) level = 0;
            drop[i] = cmwa_pkg::offset_type'(level);
            if (i + 1 < cmwa_pkg::NUM_COLUMNS) drop[i + 1] = cmwa_pkg::offset_type'(level);
         end
      endfunction

      // Moves every column one frame; true when all had already reached the bottom.
      function bit fall_one_frame();
         bit all_down;
         int v;
         int step;
         all_down = 1'b1;
         foreach (drop[i]) begin
            v = int'(drop[i]);
            if (v < 0) begin
               v = v + 1;
               all_down = 1'b0;
            end else if (v < 16) begin
               v = v + v + 1;
               all_down = 1'b0;
            end else if (v < cmwa_pkg::SCREEN_ROWS) begin
               step = cmwa_pkg::SCREEN_ROWS / 16;
               if (cmwa_pkg::SCREEN_ROWS - v < step) step = cmwa_pkg::SCREEN_ROWS - v;
               v = v + step;
               all_down = 1'b0;
            end
            drop[i] = cmwa_pkg::offset_type'(v);
         end
         return all_down;
      endfunction

      // Works out the result of an accepted item and queues it.
      function void note_item(cmwa_pkg::req_type it);
         cmwa_pkg::rsp_type want;
         int                c;
         int                r;
         want = '0;
         if (it.opcode == cmwa_pkg::OP_TICK) begin
            ticks++;
            if (!active) begin
               active = 1'b1;
               seed_columns();
            end
            want.done_res = fall_one_frame();
            if (want.done_res) begin
               active = 1'b0;
               wipes_done++;
            end
         end else begin
            queries++;
            c = 0;
            if (it.column < cmwa_pkg::NUM_COLUMNS) c = int'(drop[it.column]);
            if (c < 0) c = 0;
            r = int'(it.row);
            if (r < c) begin
               want.from_end   = 1'b1;
               want.source_row = it.row;
               end_reads++;
            end else begin
               want.source_row = 8'(r - c);
            end
         end
         pending_rsp.push_back(want);
      endfunction

      // Prints one line per mismatch, up to a cap, and counts all of them.
      task report(string what, int got_val, int want_val);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_val,
                     want_val);
      endtask

      // Compares an accepted result with the oldest prediction.
      task check_result(cmwa_pkg::rsp_type got);
         cmwa_pkg::rsp_type want;
         if (pending_rsp.size() == 0) begin
            report("result with nothing pending", int'(got), 0);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.done_res !== want.done_res)
            report("done_res", int'(got.done_res), int'(want.done_res));
         if (got.from_end !== want.from_end)
            report("from_end", int'(got.from_end), int'(want.from_end));
         if (got.source_row !== want.source_row)
            report("source_row", int'(got.source_row), int'(want.source_row));
      endtask
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   cmwa_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   cmwa_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [31:0]       csr_wr_data = '0;

   wipe_scoreboard  board;
   int              burst_left  = 0;
   int              cycles      = 0;
   int              mode_left   = 0;
   int              stall_run   = 0;
   stall_style_type stall_style = STALL_NONE;

   column_melt_wipe_addresser DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   // Result side: check accepted results, then pick the next stall from a shifting pattern.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 2));
            mode_left   = $urandom_range(100, 400);
         end
         mode_left--;
         case (stall_style)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_SCATTER: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
               if (stall_run == 0 && $urandom_range(0, 7) == 0) stall_run = $urandom_range(2, 16);
               if (stall_run > 0) begin
                  stall_run--;
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               board.pending_rsp.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic cmwa_pkg::req_type query_item(int col, int row);
      cmwa_pkg::req_type it;
      it.opcode = cmwa_pkg::OP_QUERY;
      it.column = 8'(col);
      it.row    = 8'(row);
      return it;
   endfunction

   // Ticks carry random column and row bits, which the block ignores.
   function automatic cmwa_pkg::req_type tick_item();
      cmwa_pkg::req_type it;
      it.opcode = cmwa_pkg::OP_TICK;
      it.column = 8'($urandom_range(0, 255));
      it.row    = 8'($urandom_range(0, 255));
      return it;
   endfunction

   // Offers one item in bursts with random gaps and waits until it is taken.
   task automatic push_item(input cmwa_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 3))
            0:       gap = 0;
            3:       gap = $urandom_range(5, 30);
            default: gap = $urandom_range(1, 3);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      board.note_item(it);
   endtask

   // Holds the sender off until every predicted result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.seed = value;
   endtask

   // Queries a column just above and at its current drop boundary.
   task automatic probe_boundary(input int col);
      int c;
      c = int'(board.drop[col]);
      if (c < 0) c = 0;
      push_item(query_item(col, (c > 0) ? c - 1 : 0));
      push_item(query_item(col, (c > 255) ? 255 : c));
   endtask

   // Random mix of ticks and queries; a third of in-range queries land near the boundary.
   task automatic run_random(input int count, input int tick_pct);
      cmwa_pkg::req_type it;
      int                col;
      int                c;
      int                r;
      repeat (count) begin
         if ($urandom_range(0, 99) < tick_pct) begin
            it = tick_item();
         end else begin
            if ($urandom_range(0, 9) == 0) col = $urandom_range(cmwa_pkg::NUM_COLUMNS, 255);
            else col = $urandom_range(0, cmwa_pkg::NUM_COLUMNS - 1);
            r = $urandom_range(0, 255);
            if (col < cmwa_pkg::NUM_COLUMNS && $urandom_range(0, 2) == 0) begin
               c = int'(board.drop[col]);
               if (c < 0) c = 0;
               r = c - 1 + int'($urandom_range(0, 2));
               if (r < 0) r = 0;
               if (r > 255) r = 255;
            end
            it = query_item(col, r);
         end
         push_item(it);
      end
   endtask

   initial begin
      logic [31:0] seed_list[6];
      board = new();
      seed_list = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h0000_0001, $urandom, GEN_INIT};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Queries before any wipe, with field extremes and out-of-range column and row.
      push_item(query_item(0, 0));
      push_item(query_item(cmwa_pkg::NUM_COLUMNS - 1, cmwa_pkg::SCREEN_ROWS - 1));
      push_item(query_item(255, 255));
      push_item(query_item(cmwa_pkg::NUM_COLUMNS, 128));

      // The first tick starts a wipe with the reset seed.
      push_item(tick_item());
      push_item(query_item(0, 0));
      push_item(query_item(1, 15));
      push_item(query_item(cmwa_pkg::NUM_COLUMNS - 2, 255));
      push_item(query_item(cmwa_pkg::NUM_COLUMNS - 1, 0));
      push_item(query_item(200, 7));
      repeat (6) push_item(tick_item());
      probe_boundary(0);
      probe_boundary(cmwa_pkg::NUM_COLUMNS / 2);
      probe_boundary(cmwa_pkg::NUM_COLUMNS - 1);
      wait_for_results();

      // Random phases, each under a new seed, alternating tick-heavy and query-heavy mixes.
      for (int p = 0; p < 6; p++) begin
         write_seed(seed_list[p]);
         run_random(PHASE_ITEMS, (p % 2 == 0) ? 35 : 12);
         wait_for_results();
      end

      repeat (TICK_CYCLES) @(posedge clock);
      $display("Ran %0d ticks, %0d wipes to completion, and %0d pixel queries (%0d from end frame).",
               board.ticks, board.wipes_done, board.queries, board.end_reads);
      $display("Seeds covered zero, all ones, one, the reset value and random values.");
      if (board.errors == 0 && board.pending_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing", board.errors, board.pending_rsp.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/cmwa_pkg.sv
sv/cmwa_ram.sv
sv/cmwa_cell.sv
sv/cmwa_seeder.sv
sv/column_melt_wipe_addresser.sv
test/column_melt_wipe_addresser_test.sv
